FILE: design/dead_zone_camera_follow_macros.svh
// ---------------------------------------------------------------------------
// Dead-zone camera follow: assertion macros
// Shared property wrappers for the checker; sampled on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef DEAD_ZONE_CAMERA_FOLLOW_MACROS_SVH
`define DEAD_ZONE_CAMERA_FOLLOW_MACROS_SVH

// Same-cycle implication.
`define DZCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DZCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dzcf_pkg.sv
// ---------------------------------------------------------------------------
// dzcf_pkg
// Widths, register indexes, reset values and shared types of the camera
// dead-zone follow block.
// ---------------------------------------------------------------------------
package dzcf_pkg;

  localparam int unsigned POS_W      = 15;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CALC_W     = 18;  // holds target - pos - offset
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_THR_UP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DOWN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_LO_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_LO_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_HI_X  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_HI_Y  = 3'd7;

  localparam logic [THR_W-1:0] THR_UP_RST   = 8'd40;
  localparam logic [THR_W-1:0] THR_DOWN_RST = 8'd10;
  localparam logic [THR_W-1:0] THR_SIDE_RST = 8'd22;

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [CALC_W-1:0]  calc_t;

  localparam calc_t  FRAME_OFF_X = 18'sd54;
  localparam calc_t  FRAME_OFF_Y = 18'sd96;
  localparam coord_t VIEW_OFF_X  = 16'sd120;
  localparam coord_t VIEW_OFF_Y  = 16'sd80;

  // Per-axis settings: neg = left/up, pos = right/down.
  typedef struct packed {
    logic [THR_W-1:0] thr_neg;
    logic [THR_W-1:0] thr_pos;
    pos_t             lim_lo;
    pos_t             lim_hi;
  } axis_cfg_t;

endpackage

FILE: design/dead_zone_camera_follow.sv
// ---------------------------------------------------------------------------
// dead_zone_camera_follow
// Camera position tracker with a per-direction dead zone and limit clamp.
//
//   channel  direction  payload
//   in_*     slave      tuser: target_present; tdata: target_x, target_y
//   out_*    master     tdata: camera_x, camera_y, view_center_x, view_center_y
//   cfg_*    write      index 0..7, thresholds and limits
//
// One transfer per cycle sustained while the output is not stalled; an input
// transfer passes the input register, then the result register, to out_tvalid.
// The position update is combinational: add, compare and clamp per axis.
// rst_n (synchronous) restores thresholds, zero limits and zero position.
// A stalled output holds its result; the input register keeps taking a
// transfer while the output register is free or being drained.
// ---------------------------------------------------------------------------
module dead_zone_camera_follow (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dzcf_pkg::IN_DATA_W-1:0]    in_tdata,   // target_x, target_y
  input  logic                              in_tuser,   // target_present
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // camera_x, camera_y, view_center_x, view_center_y, zero pad
  output logic [dzcf_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [dzcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dzcf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [dzcf_pkg::THR_W-1:0] thr_up_r, thr_down_r, thr_left_r, thr_right_r;
  dzcf_pkg::pos_t lim_lo_x_r, lim_lo_y_r, lim_hi_x_r, lim_hi_y_r;
  dzcf_pkg::pos_t pos_x_r, pos_y_r;
  dzcf_pkg::pos_t pos_x_nxt, pos_y_nxt;

  logic             s1_vld_r;
  logic             s1_present_r;
  dzcf_pkg::coord_t s1_tx_r, s1_ty_r;
  logic             out_vld_r;
  dzcf_pkg::pos_t   out_cx_r, out_cy_r;
  dzcf_pkg::coord_t out_vx_r, out_vy_r;

  logic in_xfer;
  logic advance;

  dzcf_pkg::axis_cfg_t cfg_x, cfg_y;

  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  assign cfg_x = '{thr_neg: thr_left_r, thr_pos: thr_right_r,
                   lim_lo: lim_lo_x_r, lim_hi: lim_hi_x_r};
  assign cfg_y = '{thr_neg: thr_up_r, thr_pos: thr_down_r,
                   lim_lo: lim_lo_y_r, lim_hi: lim_hi_y_r};

  dzcf_axis u_axis_x (
    .present   (s1_present_r),
    .pos       (pos_x_r),
    .target    (s1_tx_r),
    .frame_off (dzcf_pkg::FRAME_OFF_X),
    .cfg       (cfg_x),
    .pos_nxt   (pos_x_nxt)
  );

  dzcf_axis u_axis_y (
    .present   (s1_present_r),
    .pos       (pos_y_r),
    .target    (s1_ty_r),
    .frame_off (dzcf_pkg::FRAME_OFF_Y),
    .cfg       (cfg_y),
    .pos_nxt   (pos_y_nxt)
  );

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_up_r    <= dzcf_pkg::THR_UP_RST;
      thr_down_r  <= dzcf_pkg::THR_DOWN_RST;
      thr_left_r  <= dzcf_pkg::THR_SIDE_RST;
      thr_right_r <= dzcf_pkg::THR_SIDE_RST;
      lim_lo_x_r  <= '0;
      lim_lo_y_r  <= '0;
      lim_hi_x_r  <= '0;
      lim_hi_y_r  <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dzcf_pkg::REG_THR_UP:    thr_up_r    <= cfg_wdata[dzcf_pkg::THR_W-1:0];
          dzcf_pkg::REG_THR_DOWN:  thr_down_r  <= cfg_wdata[dzcf_pkg::THR_W-1:0];
          dzcf_pkg::REG_THR_LEFT:  thr_left_r  <= cfg_wdata[dzcf_pkg::THR_W-1:0];
          dzcf_pkg::REG_THR_RIGHT: thr_right_r <= cfg_wdata[dzcf_pkg::THR_W-1:0];
          dzcf_pkg::REG_LIM_LO_X:  lim_lo_x_r  <= cfg_wdata;
          dzcf_pkg::REG_LIM_LO_Y:  lim_lo_y_r  <= cfg_wdata;
          dzcf_pkg::REG_LIM_HI_X:  lim_hi_x_r  <= cfg_wdata;
          dzcf_pkg::REG_LIM_HI_Y:  lim_hi_y_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (advance) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_present_r <= in_tuser;
      s1_tx_r      <= in_tdata[dzcf_pkg::COORD_W-1:0];
      s1_ty_r      <= in_tdata[2*dzcf_pkg::COORD_W-1:dzcf_pkg::COORD_W];
    end
    if (advance) begin
      out_cx_r <= pos_x_nxt;
      out_cy_r <= pos_y_nxt;
      out_vx_r <= dzcf_pkg::coord_t'(pos_x_nxt) + dzcf_pkg::VIEW_OFF_X;
      out_vy_r <= dzcf_pkg::coord_t'(pos_y_nxt) + dzcf_pkg::VIEW_OFF_Y;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_vy_r, out_vx_r, out_cy_r, out_cx_r};

endmodule

FILE: design/dzcf_axis.sv
// ---------------------------------------------------------------------------
// dzcf_axis
// One axis of the follow update: dead-zone overshoot, move and clamp.
// ---------------------------------------------------------------------------
module dzcf_axis (
  input  logic               present,
  input  dzcf_pkg::pos_t     pos,
  input  dzcf_pkg::coord_t   target,
  input  dzcf_pkg::calc_t    frame_off,
  input  dzcf_pkg::axis_cfg_t cfg,
  output dzcf_pkg::pos_t     pos_nxt
);

  dzcf_pkg::calc_t diff;
  dzcf_pkg::calc_t over;
  dzcf_pkg::calc_t delta;
  dzcf_pkg::calc_t moved;
  dzcf_pkg::calc_t lo;
  dzcf_pkg::calc_t hi;
  dzcf_pkg::calc_t res;

  always_comb begin
    diff = dzcf_pkg::calc_t'(target) - dzcf_pkg::calc_t'(pos) - frame_off;
    // Negative side: move by diff + thr while that stays negative.
    if (diff[dzcf_pkg::CALC_W-1]) begin
      over  = diff + dzcf_pkg::calc_t'({1'b0, cfg.thr_neg});
      delta = over[dzcf_pkg::CALC_W-1] ? over : '0;
    end else begin
      over  = diff - dzcf_pkg::calc_t'({1'b0, cfg.thr_pos});
      delta = (!over[dzcf_pkg::CALC_W-1] && (over != '0)) ? over : '0;
    end
    moved = dzcf_pkg::calc_t'(pos) + delta;
    lo    = dzcf_pkg::calc_t'(cfg.lim_lo);
    hi    = dzcf_pkg::calc_t'(cfg.lim_hi);
    // Crossed limits: a move below the low limit gives low, any other gives high.
    priority if (!present) res = dzcf_pkg::calc_t'(pos);
    else if (moved < lo)   res = lo;
    else if (moved > hi)   res = hi;
    else                   res = moved;
    pos_nxt = res[dzcf_pkg::POS_W-1:0];
  end

endmodule

FILE: design/dzcf_checker.sv
// ---------------------------------------------------------------------------
// dzcf_checker
// Port-level checks of the camera follow block, bound to the top level.
// ---------------------------------------------------------------------------
`include "dead_zone_camera_follow_macros.svh"

module dzcf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dzcf_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [15:0] cam_x_ext, cam_y_ext;

  assign cam_x_ext = {out_tdata[14], out_tdata[14:0]};
  assign cam_y_ext = {out_tdata[29], out_tdata[29:15]};

  `DZCF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output transfer changed")
  `DZCF_ASSERT_NOW(a_view_x, out_tvalid, out_tdata[45:30] == cam_x_ext + 16'd120, "view_center_x is not camera_x + 120")
  `DZCF_ASSERT_NOW(a_view_y, out_tvalid, out_tdata[61:46] == cam_y_ext + 16'd80, "view_center_y is not camera_y + 80")
  `DZCF_ASSERT_NOW(a_ready_idle, !out_tvalid, in_tready, "input stalled with empty output register")

endmodule

bind dead_zone_camera_follow dzcf_checker u_dzcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/dead_zone_camera_follow_tb.sv
// ---------------------------------------------------------------------------
// dead_zone_camera_follow_tb
// Self-checking bench for the dead-zone camera follow block. A directed table
// covers reset values, coordinate extremes, dead-zone edges, threshold
// extremes, stale positions outside new limits and crossed limits. Random
// phases follow, each under its own thresholds and limits. Every output
// transfer is compared field by field to a table view or a behavioral tracker.
// ---------------------------------------------------------------------------
module dead_zone_camera_follow_tb;
  import dzcf_pkg::*;

  typedef struct packed {
    pos_t   cam_x;
    pos_t   cam_y;
    coord_t view_x;
    coord_t view_y;
  } view_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [POS_W-1:0]     val;
    logic                 present;
    coord_t               tx;
    coord_t               ty;
    logic                 typed;
    view_t                want;
  } row_t;

  localparam view_t HOME    = '{15'd0, 15'd0, 16'd120, 16'd80};
  localparam view_t TOP     = '{15'd16383, 15'd16383, 16'd16503, 16'd16463};
  localparam view_t BOTTOM  = '{15'h4000, 15'h4000, -16'sd16264, -16'sd16304};
  localparam view_t NO_WANT = '0;

  localparam int NUM_ROWS     = 34;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_TICKS  = 258;
  localparam int IDLE_PCT     = 37;

  // Reset config first (zero limits pin the camera), then open limits and
  // walk the dead-zone edges, extremes, threshold extremes, stale position
  // outside shrunk limits and crossed limits.
  localparam row_t PLAN [0:NUM_ROWS-1] = '{
    '{1'b0, REG_THR_UP,    15'd0,     1'b0, 16'h7FFF, 16'h8000, 1'b1, HOME},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'h7FFF, 16'h7FFF, 1'b1, HOME},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'h8000, 16'h8000, 1'b1, HOME},
    '{1'b1, REG_LIM_LO_X,  15'h4000,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_LO_Y,  15'h4000,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_HI_X,  15'h3FFF,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_HI_Y,  15'h3FFF,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd54,   16'd96,   1'b1, HOME},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd76,   16'd106,  1'b1, HOME},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd77,   16'd107,  1'b1,
      '{15'd1, 15'd1, 16'd121, 16'd81}},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd32,   16'd56,   1'b1, HOME},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'h7FFF, 16'h7FFF, 1'b1, TOP},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'h8000, 16'h8000, 1'b1, BOTTOM},
    '{1'b0, REG_THR_UP,    15'd0,     1'b0, 16'd0,    16'd0,    1'b1, BOTTOM},
    '{1'b1, REG_THR_UP,    15'd0,     1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_THR_DOWN,  15'd255,   1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_THR_LEFT,  15'd255,   1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_THR_RIGHT, 15'd0,     1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd100,  16'd200,  1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'hFFFB, 16'hFFF9, 1'b0, NO_WANT},
    '{1'b1, REG_LIM_LO_X,  15'd100,   1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_HI_X,  15'd200,   1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_LO_Y,  15'h7FCE,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_HI_Y,  15'h7FEC,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd300,  16'd60,   1'b0, NO_WANT},
    '{1'b1, REG_LIM_LO_X,  15'd300,   1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_HI_X,  15'h7ED4,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_LO_Y,  15'd50,    1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b1, REG_LIM_HI_Y,  15'h7FCE,  1'b0, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd0,    16'd0,    1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'h4E20, 16'h4E20, 1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'hB1E0, 16'hB1E0, 1'b0, NO_WANT},
    '{1'b0, REG_THR_UP,    15'd0,     1'b1, 16'd1,    16'hFFFF, 1'b0, NO_WANT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;     // target_x, target_y
  logic                  in_tuser = 1'b0;   // target_present
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // camera_x, camera_y, view_x, view_y
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // tracker copy of the block's registers and position
  int thr_up_m    = int'(THR_UP_RST);
  int thr_down_m  = int'(THR_DOWN_RST);
  int thr_left_m  = int'(THR_SIDE_RST);
  int thr_right_m = int'(THR_SIDE_RST);
  int lo_x_m = 0, lo_y_m = 0, hi_x_m = 0, hi_y_m = 0;
  int cam_x_m = 0, cam_y_m = 0;

  view_t view_q [$];
  bit    steady = 1'b0;
  int    ticks = 0, tracked = 0, checked = 0, writes = 0, fails = 0;

  dead_zone_camera_follow uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int dead_zone_step(int d, int thr_neg, int thr_pos);
    int mag;
    int over;
    mag  = d < 0 ? -d : d;
    over = mag - (d < 0 ? thr_neg : thr_pos);
    if (over <= 0) return 0;
    return d < 0 ? -over : over;
  endfunction

  function automatic int clamp_axis(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic view_t track_target(logic present, coord_t tx, coord_t ty);
    int    dx, dy, vx, vy;
    view_t v;
    if (present) begin
      dx = int'(tx) - (cam_x_m + int'(FRAME_OFF_X));
      dy = int'(ty) - (cam_y_m + int'(FRAME_OFF_Y));
      cam_x_m = clamp_axis(cam_x_m + dead_zone_step(dx, thr_left_m, thr_right_m),
                           lo_x_m, hi_x_m);
      cam_y_m = clamp_axis(cam_y_m + dead_zone_step(dy, thr_up_m, thr_down_m),
                           lo_y_m, hi_y_m);
    end
    vx = cam_x_m + int'(VIEW_OFF_X);
    vy = cam_y_m + int'(VIEW_OFF_Y);
    v.cam_x  = cam_x_m[POS_W-1:0];
    v.cam_y  = cam_y_m[POS_W-1:0];
    v.view_x = vx[COORD_W-1:0];
    v.view_y = vy[COORD_W-1:0];
    return v;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
    case (idx)
      REG_THR_UP:    thr_up_m    = int'(val[THR_W-1:0]);
      REG_THR_DOWN:  thr_down_m  = int'(val[THR_W-1:0]);
      REG_THR_LEFT:  thr_left_m  = int'(val[THR_W-1:0]);
      REG_THR_RIGHT: thr_right_m = int'(val[THR_W-1:0]);
      REG_LIM_LO_X:  lo_x_m      = int'($signed(val));
      REG_LIM_LO_Y:  lo_y_m      = int'($signed(val));
      REG_LIM_HI_X:  hi_x_m      = int'($signed(val));
      REG_LIM_HI_Y:  hi_y_m      = int'($signed(val));
      default: ;
    endcase
  endfunction

  // leaves cfg_we high; the caller drops it once the batch is done
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    writes++;
  endtask

  // leaves in_tvalid high after the transfer so back-to-back ticks need no gap
  task automatic send_tick(logic present, coord_t tx, coord_t ty, logic typed,
                           view_t want);
    view_t v;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= present;
    in_tdata  <= {ty, tx};
    do @(posedge clk); while (!in_tready);
    v = track_target(present, tx, ty);
    view_q.push_back(typed ? want : v);
    ticks++;
    if (present) tracked++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic pick_limits(input int mode, output int lo, output int hi);
    int t;
    lo = int'($urandom_range(32767)) - 16384;
    hi = lo + int'($urandom_range(3000));
    if (hi > 16383) hi = 16383;
    case (mode)
      0: begin lo = -16384; hi = 16383; end
      2: begin t = lo; lo = hi; hi = t; end  // crossed
      3: hi = lo;
      default: ;
    endcase
  endtask

  task automatic random_settings(int phase);
    logic [POS_W-1:0] w [4];
    int               thr, k, lx, hx, ly, hy;
    for (k = 0; k < 4; k++) begin
      case (phase)
        0: thr = k == 0 ? int'(THR_UP_RST) : k == 1 ? int'(THR_DOWN_RST)
                                                   : int'(THR_SIDE_RST);
        1: thr = 0;
        2: thr = 255;
        default: thr = $urandom_range(255);
      endcase
      // upper bits of a threshold write carry noise
      w[k] = POS_W'($urandom);
      w[k][THR_W-1:0] = thr[THR_W-1:0];
    end
    pick_limits(phase < 2 ? 0 : $urandom_range(3), lx, hx);
    pick_limits(phase < 2 ? 0 : $urandom_range(3), ly, hy);
    write_reg(REG_THR_UP,    w[0]);
    write_reg(REG_THR_DOWN,  w[1]);
    write_reg(REG_THR_LEFT,  w[2]);
    write_reg(REG_THR_RIGHT, w[3]);
    write_reg(REG_LIM_LO_X,  lx[POS_W-1:0]);
    write_reg(REG_LIM_LO_Y,  ly[POS_W-1:0]);
    write_reg(REG_LIM_HI_X,  hx[POS_W-1:0]);
    write_reg(REG_LIM_HI_Y,  hy[POS_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // output side: check on transfer, then pick the next ready
  always @(posedge clk) begin
    view_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cam_x  = out_tdata[14:0];
      got.cam_y  = out_tdata[29:15];
      got.view_x = out_tdata[45:30];
      got.view_y = out_tdata[61:46];
      if (view_q.size() == 0) begin
        $error("unexpected output transfer: %h", out_tdata);
        fails++;
      end else begin
        want = view_q.pop_front();
        checked++;
        if (got.cam_x !== want.cam_x) begin
          $error("camera_x: expected %0d, got %0d", want.cam_x, got.cam_x);
          fails++;
        end
        if (got.cam_y !== want.cam_y) begin
          $error("camera_y: expected %0d, got %0d", want.cam_y, got.cam_y);
          fails++;
        end
        if (got.view_x !== want.view_x) begin
          $error("view_center_x: expected %0d, got %0d", want.view_x, got.view_x);
          fails++;
        end
        if (got.view_y !== want.view_y) begin
          $error("view_center_y: expected %0d, got %0d", want.view_y, got.view_y);
          fails++;
        end
      end
    end
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
  end

  initial begin
    int     r, n, pick;
    int     tx_i, ty_i;
    logic   present;
    bit     prev_cfg;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_cfg = 1'b0;
    for (r = 0; r < NUM_ROWS; r++) begin
      if (PLAN[r].is_cfg) begin
        if (!prev_cfg) wait_drained();
        write_reg(PLAN[r].idx, PLAN[r].val);
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        send_tick(PLAN[r].present, PLAN[r].tx, PLAN[r].ty, PLAN[r].typed,
                  PLAN[r].want);
      end
      prev_cfg = PLAN[r].is_cfg;
    end

    for (r = 0; r < RAND_PHASES; r++) begin
      // sender holds off until the block is empty before reprogramming
      wait_drained();
      random_settings(r);
      steady = r == 1;
      for (n = 0; n < PHASE_TICKS; n++) begin
        present = $urandom_range(99) < 88;
        pick = $urandom_range(99);
        if (pick < 70) begin
          // around the frame center so the dead-zone edges get hit often
          tx_i = cam_x_m + int'(FRAME_OFF_X) + int'($urandom_range(600)) - 300;
          ty_i = cam_y_m + int'(FRAME_OFF_Y) + int'($urandom_range(600)) - 300;
        end else if (pick < 90) begin
          tx_i = $urandom;
          ty_i = $urandom;
        end else begin
          case ($urandom_range(3))
            0: tx_i = 32767;
            1: tx_i = -32768;
            2: tx_i = 0;
            default: tx_i = -1;
          endcase
          ty_i = $urandom_range(1) ? -32768 : 32767;
        end
        send_tick(present, tx_i[COORD_W-1:0], ty_i[COORD_W-1:0], 1'b0, NO_WANT);
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Sent %0d ticks (%0d with a target) over %0d register writes,",
             ticks, tracked, writes);
    $display("checked %0d results across directed and %0d random settings.",
             checked, RAND_PHASES);
    if (fails == 0 && view_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
